// ===== rtl/core/ipv4hg_pkg.sv =====
// Shared constants and types for the IPv4 header generator.
package ipv4hg_pkg;

   localparam int HDR_BYTES = 20;
   localparam int IDX_W = 5;
   localparam logic [IDX_W-1:0] BYTE_FIRST = '0;
   localparam logic [IDX_W-1:0] BYTE_LAST = IDX_W'(HDR_BYTES - 1);

   localparam logic [7:0] VER_IHL = 8'h45;
   localparam logic [7:0] TTL_VAL = 8'h40;
   localparam int SUM_W = 20;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_IP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GATEWAY_IP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 2'd2;

   localparam logic [31:0] LOCAL_IP_RST = 32'h0A00_020F;
   localparam logic [31:0] GATEWAY_IP_RST = 32'h0A00_0202;
   localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1500;

   typedef struct packed {
      logic [31:0] local_ip;
      logic [31:0] gateway_ip;
      logic [15:0] max_payload;
   } cfg_type;

   typedef struct packed {
      logic             rejected;
      logic [15:0]      total_len;
      logic [15:0]      ident;
      logic [7:0]       protocol;
      logic [31:0]      src_ip;
      logic [31:0]      dst_ip;
      logic [31:0]      hop_ip;
      logic [SUM_W-1:0] csum_sum;
   } hdr_type;

endpackage

// ===== rtl/core/ipv4hg_if.sv =====
// Request and response channel interfaces of the IPv4 header generator.
interface ipv4hg_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] dst_ip;
   logic [7:0]  protocol;
   logic [15:0] data_len;

   modport source (output valid, output dst_ip, output protocol, output data_len,
                   input ready);
   modport sink (input valid, input dst_ip, input protocol, input data_len,
                 output ready);
endinterface

interface ipv4hg_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  hdr_byte;
   logic [4:0]  byte_index;
   logic        last;
   logic        rejected;
   logic [31:0] hop_ip;

   modport source (output valid, output hdr_byte, output byte_index, output last,
                   output rejected, output hop_ip, input ready);
   modport sink (input valid, input hdr_byte, input byte_index, input last,
                 input rejected, input hop_ip, output ready);
endinterface

// ===== rtl/core/ipv4hg_csr.sv =====
// Configuration registers of the IPv4 header generator.
module ipv4hg_csr
   import ipv4hg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_LOCAL_IP:    cfg_in.local_ip = csr_wdata[31:0];
            CSR_GATEWAY_IP:  cfg_in.gateway_ip = csr_wdata[31:0];
            CSR_MAX_PAYLOAD: cfg_in.max_payload = csr_wdata[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.local_ip <= LOCAL_IP_RST;
         cfg_ff.gateway_ip <= GATEWAY_IP_RST;
         cfg_ff.max_payload <= MAX_PAYLOAD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/ipv4hg_build.sv =====
// Request register, identification counter and header field assembly.
module ipv4hg_build
   import ipv4hg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ipv4hg_req_if.sink  req_ch,
   input  cfg_type     cfg,
   input  logic        take,
   output logic        hdr_valid,
   output hdr_type     hdr
);

   logic        in_valid_ff, in_valid_in;
   logic [31:0] dst_ff;
   logic [7:0]  proto_ff;
   logic [15:0] plen_ff;
   logic [15:0] ident_ff, ident_in;
   logic        accept;
   logic        rejected;
   logic [15:0] total_len;

   assign req_ch.ready = !in_valid_ff || take;
   assign accept = req_ch.valid && req_ch.ready;

   assign rejected = plen_ff > cfg.max_payload;
   assign total_len = plen_ff + 16'(HDR_BYTES);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) in_valid_in = 1'b0;
      if (accept) in_valid_in = 1'b1;
      ident_in = (take && !rejected) ? ident_ff + 16'd1 : ident_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         ident_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         ident_ff <= ident_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dst_ff <= req_ch.dst_ip;
         proto_ff <= req_ch.protocol;
         plen_ff <= req_ch.data_len;
      end
   end

   always_comb begin
      hdr.rejected = rejected;
      hdr.total_len = total_len;
      hdr.ident = ident_ff;
      hdr.protocol = proto_ff;
      hdr.src_ip = cfg.local_ip;
      hdr.dst_ip = dst_ff;
      hdr.hop_ip = (dst_ff == cfg.local_ip) ? dst_ff : cfg.gateway_ip;
      hdr.csum_sum = {4'b0, VER_IHL, 8'h00} + {4'b0, total_len} + {4'b0, ident_ff}
                   + {4'b0, TTL_VAL, proto_ff}
                   + {4'b0, cfg.local_ip[31:16]} + {4'b0, cfg.local_ip[15:0]}
                   + {4'b0, dst_ff[31:16]} + {4'b0, dst_ff[15:0]};
   end

   assign hdr_valid = in_valid_ff;

endmodule

// ===== rtl/core/ipv4hg_emit.sv =====
// Header holding register and byte serializer with output register.
module ipv4hg_emit
   import ipv4hg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        hdr_valid,
   input  hdr_type     hdr,
   output logic        take,
   ipv4hg_rsp_if.source rsp_ch
);

   hdr_type          hdr_ff;
   logic             active_ff, active_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff;
   logic [IDX_W-1:0] out_idx_ff;
   logic             out_last_ff;
   logic             out_rej_ff;
   logic [31:0]      out_hop_ff;
   logic             out_free;
   logic             finishing;
   logic             emit;
   logic [16:0]      fold1;
   logic [15:0]      fold2;
   logic [15:0]      csum;
   logic [7:0]       byte_sel;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign finishing = hdr_ff.rejected || (idx_ff == BYTE_LAST);
   assign take = hdr_valid && (!active_ff || (out_free && finishing));
   assign emit = active_ff && out_free;

   assign fold1 = {1'b0, hdr_ff.csum_sum[15:0]} + {13'b0, hdr_ff.csum_sum[SUM_W-1:16]};
   assign fold2 = fold1[15:0] + {15'b0, fold1[16]};
   assign csum = ~fold2;

   always_comb begin
      case (idx_ff)
         5'd0:    byte_sel = VER_IHL;
         5'd2:    byte_sel = hdr_ff.total_len[15:8];
         5'd3:    byte_sel = hdr_ff.total_len[7:0];
         5'd4:    byte_sel = hdr_ff.ident[15:8];
         5'd5:    byte_sel = hdr_ff.ident[7:0];
         5'd8:    byte_sel = TTL_VAL;
         5'd9:    byte_sel = hdr_ff.protocol;
         5'd10:   byte_sel = csum[15:8];
         5'd11:   byte_sel = csum[7:0];
         5'd12:   byte_sel = hdr_ff.src_ip[31:24];
         5'd13:   byte_sel = hdr_ff.src_ip[23:16];
         5'd14:   byte_sel = hdr_ff.src_ip[15:8];
         5'd15:   byte_sel = hdr_ff.src_ip[7:0];
         5'd16:   byte_sel = hdr_ff.dst_ip[31:24];
         5'd17:   byte_sel = hdr_ff.dst_ip[23:16];
         5'd18:   byte_sel = hdr_ff.dst_ip[15:8];
         5'd19:   byte_sel = hdr_ff.dst_ip[7:0];
         default: byte_sel = 8'h00;
      endcase
   end

   always_comb begin
      active_in = active_ff;
      idx_in = idx_ff;
      if (emit) begin
         idx_in = idx_ff + IDX_W'(1);
         if (finishing) active_in = 1'b0;
      end
      if (take) begin
         active_in = 1'b1;
         idx_in = BYTE_FIRST;
      end
      out_valid_in = emit || (out_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff <= BYTE_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         idx_ff <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) hdr_ff <= hdr;
      if (emit) begin
         out_byte_ff <= hdr_ff.rejected ? 8'h00 : byte_sel;
         out_idx_ff <= hdr_ff.rejected ? BYTE_FIRST : idx_ff;
         out_last_ff <= finishing;
         out_rej_ff <= hdr_ff.rejected;
         out_hop_ff <= (!hdr_ff.rejected && idx_ff == BYTE_FIRST) ? hdr_ff.hop_ip : 32'h0;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.hdr_byte = out_byte_ff;
   assign rsp_ch.byte_index = out_idx_ff;
   assign rsp_ch.last = out_last_ff;
   assign rsp_ch.rejected = out_rej_ff;
   assign rsp_ch.hop_ip = out_hop_ff;

`ifndef SYNTHESIS
   a_rej_single: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.rejected |-> rsp_ch.last && rsp_ch.byte_index == BYTE_FIRST)
      else $error("rejected word is not a single last word at index zero");
   a_last_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.last && !rsp_ch.rejected |-> rsp_ch.byte_index == BYTE_LAST)
      else $error("last header word not at final index");
   a_hop_first: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.byte_index != BYTE_FIRST |-> rsp_ch.hop_ip == 32'h0)
      else $error("next hop on a word other than the first");
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && !rsp_ch.last |=> rsp_ch.valid)
      else $error("gap inside a header");
`endif

endmodule

// ===== rtl/core/ipv4hg_core.sv =====
// Top level of the IPv4 header generator.
// Each accepted request yields the 20-byte IPv4 header, one word per cycle while rsp_ch
// is ready, and a new request is taken as the last byte of the previous one enters the
// output register; a request whose payload length exceeds max_payload yields one
// rejected word. With the serializer idle, the first word passes from the request
// register, which loads at the accepting edge, through the header register and then the
// output register. One more request can wait in the request register while a header
// is being sent. The identification field counts accepted, non-rejected requests.
// Configuration writes take effect on the next cycle and must be made by the user only
// while the block is idle; the block itself does not enforce this.
module ipv4_header_generator_core
   import ipv4hg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   ipv4hg_req_if.sink            req_ch,
   ipv4hg_rsp_if.source          rsp_ch
);

   cfg_type cfg;
   hdr_type hdr;
   logic    hdr_valid;
   logic    take;

   ipv4hg_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   ipv4hg_build u_build (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cfg       (cfg),
      .take      (take),
      .hdr_valid (hdr_valid),
      .hdr       (hdr)
   );

   ipv4hg_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .hdr_valid (hdr_valid),
      .hdr       (hdr),
      .take      (take),
      .rsp_ch    (rsp_ch)
   );

endmodule
